// File: src/mac_pkg.sv
// ----------------------------------------------------------------------------
// mac_pkg: shared constants and types for the mesh area and centroid block
// Holds the field widths, the derived datapath widths and the structs that
// pass between the channel interfaces, the core and the arithmetic units.
// ----------------------------------------------------------------------------
`default_nettype none

package mac_pkg;

    // Mesh capacity and coordinate width
    localparam int MAX_VERTS = 4096;
    localparam int COORD_W   = 12;

    // Result widths
    localparam int AREA_W = 40;
    localparam int CNT_W  = $clog2(MAX_VERTS + 1);

    // Datapath widths
    localparam int SUM_W   = COORD_W + $clog2(MAX_VERTS);  // coordinate sums
    localparam int EDGE_W  = COORD_W + 1;                  // triangle edges
    localparam int CROSS_W = 2 * EDGE_W + 1;               // one cross component
    localparam int MAG_W   = 2 * EDGE_W;                   // multiplier operand
    localparam int SQ_W    = 2 * MAG_W;                    // product, sum of squares
    localparam int ROOT_W  = SQ_W / 2;
    localparam int ROOT_STEPS = SQ_W / 2;
    localparam int STEP_W  = $clog2((SUM_W > ROOT_STEPS) ? SUM_W : ROOT_STEPS);

    localparam logic [SQ_W-1:0] SQRT_TOP = SQ_W'(1) << (SQ_W - 2);

    typedef struct packed {
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
        logic signed [COORD_W-1:0] vz;
        logic                      last;
    } vtx_t;

    typedef struct packed {
        logic [AREA_W-1:0]         total_area;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic [CNT_W-1:0]          vertex_count;
        logic                      overflow;
    } res_t;

    // Result of the shared compare-subtract unit
    typedef struct packed {
        logic            ge;
        logic [SQ_W-1:0] diff;
    } cs_t;

endpackage

`default_nettype wire

// File: src/mac_vtx_if.sv
// ----------------------------------------------------------------------------
// mac_vtx_if: vertex channel
// Valid/ready channel that carries one mesh vertex per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface mac_vtx_if
    import mac_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic signed [COORD_W-1:0] vz;
    logic                      last;

    modport source (output valid, output vx, output vy, output vz, output last,
                    input ready);
    modport sink   (input valid, input vx, input vy, input vz, input last,
                    output ready);
endinterface

`default_nettype wire

// File: src/mac_res_if.sv
// ----------------------------------------------------------------------------
// mac_res_if: result channel
// Valid/ready channel that carries the area, centroid and count of one mesh.
// ----------------------------------------------------------------------------
`default_nettype none

interface mac_res_if
    import mac_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [AREA_W-1:0]         total_area;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [CNT_W-1:0]          vertex_count;
    logic                      overflow;

    modport source (output valid, output total_area, output center_x,
                    output center_y, output center_z, output vertex_count,
                    output overflow, input ready);
    modport sink   (input valid, input total_area, input center_x,
                    input center_y, input center_z, input vertex_count,
                    input overflow, output ready);
endinterface

`default_nettype wire

// File: src/mac_mul.sv
// ----------------------------------------------------------------------------
// mac_mul: shared signed multiplier
// One signed multiply with its product registered; serves every cross
// product term and every square of the area computation.
// ----------------------------------------------------------------------------
`default_nettype none

module mac_mul
    import mac_pkg::*;
(
    input  logic                    clk,
    input  logic signed [MAG_W-1:0] a,
    input  logic signed [MAG_W-1:0] b,
    output logic signed [SQ_W-1:0]  prod
);

    logic signed [SQ_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// File: src/mac_cmpsub.sv
// ----------------------------------------------------------------------------
// mac_cmpsub: shared compare-subtract unit
// Compares a against b and forms a - b; one step of both the square root
// and the long division.
// ----------------------------------------------------------------------------
`default_nettype none

module mac_cmpsub
    import mac_pkg::*;
(
    input  logic [SQ_W-1:0] a,
    input  logic [SQ_W-1:0] b,
    output cs_t             cs
);

    logic [SQ_W:0] diff_wide;

    always_comb
    begin
        diff_wide = {1'b0, a} - {1'b0, b};
        cs.ge     = ~diff_wide[SQ_W];
        cs.diff   = diff_wide[SQ_W-1:0];
    end

endmodule

`default_nettype wire

// File: src/mac_core.sv
// ----------------------------------------------------------------------------
// mac_core: mesh accumulation sequencer
// Takes vertices, forms triangle edges, drives the shared multiplier through
// the cross product and its squared length, takes the square root and the
// per-axis division of the centroid on the shared compare-subtract unit.
// ----------------------------------------------------------------------------
`default_nettype none

module mac_core
    import mac_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic vtx_valid,
    output logic vtx_ready,
    input  vtx_t vtx,
    output logic emit_valid,
    input  logic emit_taken,
    output res_t emit_word
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CROSS = 3'd1;
    localparam logic [2:0] ST_SQRT  = 3'd2;
    localparam logic [2:0] ST_AREA  = 3'd3;
    localparam logic [2:0] ST_DLOAD = 3'd4;
    localparam logic [2:0] ST_DSTEP = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    // Steps of one cross component
    localparam logic [STEP_W-1:0] J_MUL_P  = STEP_W'(0);
    localparam logic [STEP_W-1:0] J_MUL_Q  = STEP_W'(1);
    localparam logic [STEP_W-1:0] J_SUB    = STEP_W'(2);
    localparam logic [STEP_W-1:0] J_SQUARE = STEP_W'(3);
    localparam logic [STEP_W-1:0] J_ACC    = STEP_W'(4);

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    logic [2:0]          state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [1:0]          idx_reg;
    logic [1:0]          phase_reg;
    logic [CNT_W-1:0]    seen_reg;
    logic                dropped_reg;
    logic                last_reg;

    logic signed [COORD_W-1:0] held_reg [2][3];
    logic signed [SUM_W-1:0]   sum_reg [3];
    logic signed [EDGE_W-1:0]  e1_reg [3];
    logic signed [EDGE_W-1:0]  e2_reg [3];
    logic signed [CROSS_W-1:0] cr_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic [SQ_W-1:0]           rem_reg;
    logic [SQ_W-1:0]           res_reg;
    logic [SQ_W-1:0]           bit_reg;
    logic [AREA_W-1:0]         area_reg;
    logic [SUM_W-1:0]          dq_reg;
    logic signed [COORD_W-1:0] center_reg [3];

    logic signed [COORD_W-1:0] v [3];
    logic                      accept;
    logic                      full;
    logic [1:0]                u_idx;
    logic [1:0]                w_idx;
    logic signed [CROSS_W-1:0] cr_abs;
    logic signed [MAG_W-1:0]   mul_a;
    logic signed [MAG_W-1:0]   mul_b;
    logic signed [SQ_W-1:0]    prod;
    logic [SQ_W-1:0]           sq_base;
    logic [SQ_W-1:0]           cs_a;
    logic [SQ_W-1:0]           cs_b;
    cs_t                       cs;
    logic [SQ_W-1:0]           rem_sh;
    logic [SUM_W-1:0]          quot;
    logic [SUM_W-1:0]          quot_signed;
    logic [SUM_W-1:0]          sum_mag;
    logic [AREA_W:0]           area_wide;

    assign v[0] = vtx.vx;
    assign v[1] = vtx.vy;
    assign v[2] = vtx.vz;

    assign vtx_ready = (state_reg == ST_IDLE);
    assign accept    = vtx_valid && vtx_ready;
    assign full      = (seen_reg >= CNT_W'(MAX_VERTS));

    // Component k of the cross product is e1[u]*e2[w] - e1[w]*e2[u]
    always_comb
    begin
        unique case (idx_reg)
            AXIS_X:  begin u_idx = AXIS_Y; w_idx = AXIS_Z; end
            AXIS_Y:  begin u_idx = AXIS_Z; w_idx = AXIS_X; end
            default: begin u_idx = AXIS_X; w_idx = AXIS_Y; end
        endcase
    end

    assign cr_abs = cr_reg[CROSS_W-1] ? -cr_reg : cr_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_CROSS)
        begin
            case (step_reg)
                J_MUL_P:
                begin
                    mul_a = MAG_W'(e1_reg[u_idx]);
                    mul_b = MAG_W'(e2_reg[w_idx]);
                end
                J_MUL_Q:
                begin
                    mul_a = MAG_W'(e1_reg[w_idx]);
                    mul_b = MAG_W'(e2_reg[u_idx]);
                end
                J_SQUARE:
                begin
                    mul_a = cr_abs[MAG_W-1:0];
                    mul_b = cr_abs[MAG_W-1:0];
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    mac_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign sq_base = (idx_reg == AXIS_X) ? '0 : sq_reg;

    // Shared compare-subtract: root trial in SQRT, divisor in DSTEP
    assign rem_sh = {rem_reg[SQ_W-2:0], dq_reg[SUM_W-1]};

    always_comb
    begin
        if (state_reg == ST_SQRT)
        begin
            cs_a = rem_reg;
            cs_b = res_reg + bit_reg;
        end
        else
        begin
            cs_a = rem_sh;
            cs_b = SQ_W'(seen_reg);
        end
    end

    mac_cmpsub u_cmpsub (
        .a  (cs_a),
        .b  (cs_b),
        .cs (cs)
    );

    assign quot        = {dq_reg[SUM_W-2:0], cs.ge};
    assign quot_signed = sum_reg[idx_reg][SUM_W-1] ? (~quot + 1'b1) : quot;
    assign sum_mag     = sum_reg[idx_reg][SUM_W-1] ? SUM_W'(-sum_reg[idx_reg])
                                                   : SUM_W'(sum_reg[idx_reg]);
    assign area_wide   = {1'b0, area_reg} + (AREA_W + 1)'(res_reg[ROOT_W-1:1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            idx_reg     <= '0;
            phase_reg   <= '0;
            seen_reg    <= '0;
            dropped_reg <= 1'b0;
            last_reg    <= 1'b0;
            area_reg    <= '0;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        last_reg <= vtx.last;
                        idx_reg  <= '0;
                        step_reg <= '0;
                        if (full)
                        begin
                            dropped_reg <= 1'b1;
                            if (vtx.last)
                            begin
                                state_reg <= ST_DLOAD;
                            end
                        end
                        else
                        begin
                            seen_reg <= seen_reg + 1'b1;
                            for (int i = 0; i < 3; i++)
                            begin
                                sum_reg[i] <= sum_reg[i] + SUM_W'(v[i]);
                            end
                            if (phase_reg == 2'd2)
                            begin
                                for (int i = 0; i < 3; i++)
                                begin
                                    e1_reg[i] <= EDGE_W'(held_reg[1][i])
                                               - EDGE_W'(held_reg[0][i]);
                                    e2_reg[i] <= EDGE_W'(v[i])
                                               - EDGE_W'(held_reg[0][i]);
                                end
                                phase_reg <= '0;
                                state_reg <= ST_CROSS;
                            end
                            else
                            begin
                                for (int i = 0; i < 3; i++)
                                begin
                                    held_reg[phase_reg[0]][i] <= v[i];
                                end
                                phase_reg <= phase_reg + 1'b1;
                                if (vtx.last)
                                begin
                                    state_reg <= ST_DLOAD;
                                end
                            end
                        end
                    end
                end

                ST_CROSS:
                begin
                    step_reg <= step_reg + 1'b1;
                    case (step_reg)
                        J_MUL_Q:
                        begin
                            cr_reg <= prod[CROSS_W-1:0];
                        end
                        J_SUB:
                        begin
                            cr_reg <= cr_reg - prod[CROSS_W-1:0];
                        end
                        J_ACC:
                        begin
                            step_reg <= '0;
                            sq_reg   <= sq_base + SQ_W'(prod);
                            if (idx_reg == AXIS_Z)
                            begin
                                rem_reg   <= sq_base + SQ_W'(prod);
                                res_reg   <= '0;
                                bit_reg   <= SQRT_TOP;
                                state_reg <= ST_SQRT;
                            end
                            else
                            begin
                                idx_reg <= idx_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end

                ST_SQRT:
                begin
                    if (cs.ge)
                    begin
                        rem_reg <= cs.diff;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg  <= bit_reg >> 2;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(ROOT_STEPS - 1))
                    begin
                        state_reg <= ST_AREA;
                    end
                end

                ST_AREA:
                begin
                    // Saturate the running area at full scale
                    area_reg <= area_wide[AREA_W] ? '1 : area_wide[AREA_W-1:0];
                    idx_reg  <= '0;
                    step_reg <= '0;
                    state_reg <= last_reg ? ST_DLOAD : ST_IDLE;
                end

                ST_DLOAD:
                begin
                    dq_reg    <= sum_mag;
                    rem_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_DSTEP;
                end

                ST_DSTEP:
                begin
                    if (cs.ge)
                    begin
                        rem_reg <= cs.diff;
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                    end
                    dq_reg   <= quot;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(SUM_W - 1))
                    begin
                        center_reg[idx_reg] <= (seen_reg == '0) ? '0
                                               : quot_signed[COORD_W-1:0];
                        if (idx_reg == AXIS_Z)
                        begin
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_DLOAD;
                        end
                    end
                end

                ST_EMIT:
                begin
                    if (emit_taken)
                    begin
                        seen_reg    <= '0;
                        phase_reg   <= '0;
                        dropped_reg <= 1'b0;
                        last_reg    <= 1'b0;
                        area_reg    <= '0;
                        for (int i = 0; i < 3; i++)
                        begin
                            sum_reg[i] <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign emit_valid             = (state_reg == ST_EMIT);
    assign emit_word.total_area   = area_reg;
    assign emit_word.center_x     = center_reg[0];
    assign emit_word.center_y     = center_reg[1];
    assign emit_word.center_z     = center_reg[2];
    assign emit_word.vertex_count = seen_reg;
    assign emit_word.overflow     = dropped_reg;

endmodule

`default_nettype wire

// File: src/mesh_area_centroid.sv
// ----------------------------------------------------------------------------
// mesh_area_centroid: surface area and centroid of a triangle mesh
// Accumulates triangle areas and vertex sums over a vertex stream and hands
// out one result word per mesh through a registered output stage.
// ----------------------------------------------------------------------------
// Vertices arrive as signed Q8.4 words on vtx; every three accepted vertices
// make a triangle, and the word marked last closes the mesh and yields one
// result word on res: total area (Q.8, saturating at full scale), the
// centroid per axis (sum over count, truncated toward zero), the vertex count
// and an overflow flag. A first or second corner of a triangle leaves the
// block ready for the next vertex unless it closes the mesh. After taking the
// third corner the block holds off while it forms the cross product and its
// squared length on the shared multiplier, then the square root on the shared
// compare-subtract unit (one result bit per cycle) and the area add. The last
// vertex adds the centroid division per axis on the same compare-subtract unit
// (one quotient bit per cycle) before the result is offered.
// Incomplete trailing triangles add no area but their corners still count
// toward the centroid; vertices beyond 4096 are dropped and raise overflow.
// The next mesh may start while the previous result still waits on res.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_area_centroid
    import mac_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mac_vtx_if.sink    vtx,
    mac_res_if.source  res
);

    vtx_t vtx_word;
    logic core_ready;
    logic emit_valid;
    logic emit_taken;
    res_t emit_word;

    logic out_valid_reg;
    res_t out_word_reg;

    // Gather the vertex word
    assign vtx_word.vx   = vtx.vx;
    assign vtx_word.vy   = vtx.vy;
    assign vtx_word.vz   = vtx.vz;
    assign vtx_word.last = vtx.last;
    assign vtx.ready     = core_ready;

    mac_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .vtx_valid  (vtx.valid),
        .vtx_ready  (core_ready),
        .vtx        (vtx_word),
        .emit_valid (emit_valid),
        .emit_taken (emit_taken),
        .emit_word  (emit_word)
    );

    // Load the output stage when it is empty or being drained this cycle
    assign emit_taken = emit_valid && (!out_valid_reg || res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_taken)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_taken)
        begin
            out_word_reg <= emit_word;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.total_area   = out_word_reg.total_area;
    assign res.center_x     = out_word_reg.center_x;
    assign res.center_y     = out_word_reg.center_y;
    assign res.center_z     = out_word_reg.center_z;
    assign res.vertex_count = out_word_reg.vertex_count;
    assign res.overflow     = out_word_reg.overflow;

endmodule

`default_nettype wire

// File: bench/mesh_result_checker.sv
// ----------------------------------------------------------------------------
// mesh_result_checker: scoreboard for the mesh area and centroid block
// Watches both channels, works out the result word of every mesh from the
// accepted vertex words and compares each accepted result word with it.
// ----------------------------------------------------------------------------

module mesh_result_checker
    import mac_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic vtx_valid,
    input  logic vtx_ready,
    input  vtx_t vtx_word,
    input  logic res_valid,
    input  logic res_ready,
    input  res_t res_word,
    output int   mismatches,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned AREA_FULL  = (64'd1 << AREA_W) - 64'd1;
    localparam int unsigned     COUNT_FULL = (1 << CNT_W) - 1;

    // Running state of the mesh being collected
    vtx_t            corner_a;
    vtx_t            corner_b;
    int unsigned     corners_held;
    longint unsigned area_acc;
    longint          coord_acc [3];
    int unsigned     accepted_verts;
    logic            capacity_hit;

    res_t            mesh_results_due [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic clear_mesh();
        corner_a       = '0;
        corner_b       = '0;
        corners_held   = 0;
        area_acc       = 0;
        coord_acc      = '{0, 0, 0};
        accepted_verts = 0;
        capacity_hit   = 1'b0;
    endtask

    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned probe;
        rem   = n;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rem >= root + probe)
            begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Half the length of the edge cross product, Q.8
    function automatic longint unsigned triangle_area(input vtx_t a, input vtx_t b,
                                                      input vtx_t c);
        longint e1x, e1y, e1z, e2x, e2y, e2z;
        longint cx, cy, cz;
        longint unsigned len_sq;
        e1x = longint'(b.vx) - longint'(a.vx);
        e1y = longint'(b.vy) - longint'(a.vy);
        e1z = longint'(b.vz) - longint'(a.vz);
        e2x = longint'(c.vx) - longint'(a.vx);
        e2y = longint'(c.vy) - longint'(a.vy);
        e2z = longint'(c.vz) - longint'(a.vz);
        cx  = e1y * e2z - e1z * e2y;
        cy  = e1z * e2x - e1x * e2z;
        cz  = e1x * e2y - e1y * e2x;
        len_sq = longint'(cx * cx) + longint'(cy * cy) + longint'(cz * cz);
        return floor_sqrt(len_sq) >> 1;
    endfunction

    task automatic absorb_vertex(input vtx_t w);
        res_t   due;
        longint mean [3];
        if (accepted_verts >= MAX_VERTS)
            capacity_hit = 1'b1;
        else
        begin
            accepted_verts++;
            coord_acc[0] += longint'(w.vx);
            coord_acc[1] += longint'(w.vy);
            coord_acc[2] += longint'(w.vz);
            if (corners_held >= 2)
            begin
                area_acc = area_acc + triangle_area(corner_a, corner_b, w);
                if (area_acc > AREA_FULL)
                    area_acc = AREA_FULL;
                corners_held = 0;
            end
            else if (corners_held == 0)
            begin
                corner_a     = w;
                corners_held = 1;
            end
            else
            begin
                corner_b     = w;
                corners_held = 2;
            end
        end

        if (w.last)
        begin
            for (int k = 0; k < 3; k++)
                mean[k] = (accepted_verts != 0) ?
                          coord_acc[k] / longint'(accepted_verts) : 0;
            due.total_area   = AREA_W'(area_acc);
            due.center_x     = COORD_W'(mean[0]);
            due.center_y     = COORD_W'(mean[1]);
            due.center_z     = COORD_W'(mean[2]);
            due.vertex_count = CNT_W'((accepted_verts > COUNT_FULL) ?
                                      COUNT_FULL : accepted_verts);
            due.overflow     = capacity_hit;
            mesh_results_due.push_back(due);
            clear_mesh();
        end
    endtask

    task automatic compare_result(input res_t got);
        res_t want;
        if (mesh_results_due.size() == 0)
        begin
            report_mismatch($sformatf("result word with none due, area %0d count %0d",
                                      got.total_area, got.vertex_count));
            return;
        end
        want = mesh_results_due.pop_front();
        if (got.total_area !== want.total_area)
            report_mismatch($sformatf("total_area %0d, due %0d",
                                      got.total_area, want.total_area));
        if (got.center_x !== want.center_x)
            report_mismatch($sformatf("center_x %0d, due %0d", got.center_x, want.center_x));
        if (got.center_y !== want.center_y)
            report_mismatch($sformatf("center_y %0d, due %0d", got.center_y, want.center_y));
        if (got.center_z !== want.center_z)
            report_mismatch($sformatf("center_z %0d, due %0d", got.center_z, want.center_z));
        if (got.vertex_count !== want.vertex_count)
            report_mismatch($sformatf("vertex_count %0d, due %0d",
                                      got.vertex_count, want.vertex_count));
        if (got.overflow !== want.overflow)
            report_mismatch($sformatf("overflow %0b, due %0b", got.overflow, want.overflow));
    endtask

    // Retire the result word before taking the vertex: a result accepted on the
    // same edge always belongs to an earlier mesh.
    always @(posedge clk)
    begin
        if (!rst_n)
            clear_mesh();
        else
        begin
            if (res_valid && res_ready)
                compare_result(res_word);
            if (vtx_valid && vtx_ready)
                absorb_vertex(vtx_word);
        end
        outstanding <= mesh_results_due.size();
    end

endmodule

// File: bench/mesh_area_centroid_test.sv
// ----------------------------------------------------------------------------
// mesh_area_centroid_test: regression for the mesh area and centroid block
// Drives meshes of vertex words, directed corner cases first and random
// meshes after, under changing idle patterns on both sides, and leaves the
// checking to the scoreboard beside the block.
// ----------------------------------------------------------------------------

module mesh_area_centroid_test
    import mac_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_OFF_CYCLES = 1500;   // long receiver hold-off
    localparam int QUIET_LIMIT     = 20000;  // cycles without any accepted word
    localparam int DRAIN_CYCLES    = 200;    // tail after the last result word

    localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};

    logic        clk;
    logic        rst_n;

    int unsigned src_idle_pct;   // chance in a hundred that the sender idles
    int unsigned snk_idle_pct;   // chance in a hundred that the receiver idles
    logic        hold_off_req;   // ask the receiver for one long hold-off
    int unsigned items_sent;
    int          quiet_cycles;
    int          mismatches;
    int          outstanding;

    mac_vtx_if vtx ();
    mac_res_if res ();

    mesh_area_centroid i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .vtx   (vtx),
        .res   (res)
    );

    mesh_result_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .vtx_valid   (vtx.valid),
        .vtx_ready   (vtx.ready),
        .vtx_word    ({vtx.vx, vtx.vy, vtx.vz, vtx.last}),
        .res_valid   (res.valid),
        .res_ready   (res.ready),
        .res_word    ({res.total_area, res.center_x, res.center_y, res.center_z,
                       res.vertex_count, res.overflow}),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no word moves on either channel for too long.
    // The longest honest gap is the receiver hold-off plus a mesh's division
    // time, well under the limit.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (vtx.valid && vtx.ready) || (res.valid && res.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Receiver: drive ready at each falling edge. On request, hold ready low
    // for a long stretch so that the block backs up and stalls its input.
    // ------------------------------------------------------------------------
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                res.ready    <= 1'b0;
                hold_off_req  = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            else
                res.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Pick a coordinate: mostly full range, with extremes and values near zero
    // weighted up so that small centroids and truncation get exercised.
    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(7))
            0:       return C_MIN;
            1:       return C_MAX;
            2, 3:    return COORD_W'(int'($urandom_range(32)) - 16);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    // Offer one vertex word; entered and left just after a falling edge.
    // Keep valid high across back-to-back words, drop it only for idle cycles.
    task automatic send_vertex(input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y,
                               input logic signed [COORD_W-1:0] z,
                               input logic                      is_last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            vtx.valid <= 1'b0;
            @(negedge clk);
        end
        vtx.valid <= 1'b1;
        vtx.vx    <= x;
        vtx.vy    <= y;
        vtx.vz    <= z;
        vtx.last  <= is_last;
        do
            @(posedge clk);
        while (!vtx.ready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_mesh(input int unsigned verts);
        for (int unsigned i = 0; i < verts; i++)
            send_vertex(pick_coord(), pick_coord(), pick_coord(), i == verts - 1);
    endtask

    // Mostly short meshes, now and then a longer one; sizes land on every
    // remainder modulo three so trailing one and two corner tails both occur.
    task automatic send_random_meshes(input int unsigned item_budget);
        int unsigned goal;
        goal = items_sent + item_budget;
        while (items_sent < goal)
        begin
            if ($urandom_range(9) == 0)
                send_mesh($urandom_range(30, 90));
            else
                send_mesh($urandom_range(1, 12));
        end
    endtask

    // Pause the sender until every result word due has been taken.
    task automatic wait_results_drained();
        vtx.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        vtx.valid    = 1'b0;
        vtx.vx       = '0;
        vtx.vy       = '0;
        vtx.vz       = '0;
        vtx.last     = 1'b0;
        res.ready    = 1'b0;
        hold_off_req = 1'b0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        items_sent   = 0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --------------------------------------------------------------------
        // Directed meshes
        // --------------------------------------------------------------------
        // Single vertex: count one, no area, centroid equals the vertex
        send_vertex(C_MAX, C_MIN, 12'sd0, 1'b1);

        // Two corners only: no triangle, odd sums truncate toward zero
        send_vertex(C_MIN, C_MAX, -12'sd1, 1'b0);
        send_vertex(12'sd1, -12'sd1, C_MAX, 1'b1);

        // Largest edges in every axis
        send_vertex(C_MIN, C_MIN, C_MIN, 1'b0);
        send_vertex(C_MAX, C_MAX, C_MIN, 1'b0);
        send_vertex(C_MIN, C_MAX, C_MAX, 1'b1);

        // Collinear corners: zero area
        send_vertex(12'sd0, 12'sd0, 12'sd0, 1'b0);
        send_vertex(12'sd16, 12'sd16, 12'sd16, 1'b0);
        send_vertex(12'sd32, 12'sd32, 12'sd32, 1'b1);

        // Unit right triangle (half in Q.8) plus one trailing corner
        send_vertex(12'sd0, 12'sd0, 12'sd0, 1'b0);
        send_vertex(12'sd16, 12'sd0, 12'sd0, 1'b0);
        send_vertex(12'sd0, 12'sd16, 12'sd0, 1'b0);
        send_vertex(-12'sd5, -12'sd7, -12'sd3, 1'b1);

        // Full-scale triangle plus two trailing corners near zero
        send_vertex(C_MAX, C_MAX, C_MAX, 1'b0);
        send_vertex(C_MIN, C_MIN, C_MAX, 1'b0);
        send_vertex(C_MAX, C_MIN, C_MIN, 1'b0);
        send_vertex(-12'sd1, -12'sd1, -12'sd1, 1'b0);
        send_vertex(-12'sd2, 12'sd0, 12'sd1, 1'b1);

        wait_results_drained();

        // --------------------------------------------------------------------
        // Phase one: sender mostly busy, receiver mostly idle. Part way in,
        // hold the receiver off for a long stretch while vertices keep coming.
        // --------------------------------------------------------------------
        src_idle_pct = 10;
        snk_idle_pct = 83;
        send_random_meshes(100);
        hold_off_req = 1'b1;
        send_random_meshes(180);
        wait_results_drained();

        // Phase two: the other way round
        src_idle_pct = 83;
        snk_idle_pct = 10;
        send_random_meshes(285);
        wait_results_drained();

        // Phase three: no idling on either side
        src_idle_pct = 0;
        snk_idle_pct = 0;
        send_random_meshes(285);

        // Drain, then allow the block time to show any stray result word
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
src/mac_pkg.sv
src/mac_vtx_if.sv
src/mac_res_if.sv
src/mac_mul.sv
src/mac_cmpsub.sv
src/mac_core.sv
src/mesh_area_centroid.sv
bench/mesh_result_checker.sv
bench/mesh_area_centroid_test.sv
